// File: design/dskv_pkg.sv
// Shared types, microcode program and constants for the dual Kalman velocity core.
package dskv_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // Program counter
  localparam int PC_W = 5;
  typedef logic [PC_W-1:0] pc_t;

  // Input modes
  typedef enum logic [2:0] {
    MODE_PREDICT = 3'd0,
    MODE_WHEEL   = 3'd1,
    MODE_IMU     = 3'd2,
    MODE_ENTER   = 3'd3,
    MODE_LEAVE   = 3'd4,
    MODE_RESET   = 3'd5
  } mode_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_TIME_STEP = 3'd0,
    REG_ANG_Q     = 3'd1,
    REG_LIN_Q     = 3'd2,
    REG_WHEEL_ANG = 3'd3,
    REG_IMU_ANG   = 3'd4,
    REG_WHEEL_LIN = 3'd5,
    REG_IMU_LIN   = 3'd6
  } reg_idx_t;

  // Multiplier operand select
  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_DT,
    MUL_GAIN,
    MUL_COV
  } mul_t;

  // Datapath operation
  typedef enum logic [3:0] {
    ALU_NOP,
    ALU_LOAD,
    ALU_ROUND,
    ALU_PRED,
    ALU_SUM,
    ALU_DIV,
    ALU_UPD,
    ALU_ENTER,
    ALU_LEAVE,
    ALU_RESTORE,
    ALU_EMIT
  } alu_t;

  // Jump condition
  typedef enum logic [3:0] {
    JC_NEXT,
    JC_GOTO,
    JC_WAIT,
    JC_MODE,
    JC_SZERO,
    JC_LOOP,
    JC_FLAG_SET,
    JC_FLAG_CLR,
    JC_EMIT
  } jc_t;

  typedef struct packed {
    mul_t mul;
    alu_t alu;
    jc_t  jc;
    pc_t  target;
  } ctl_t;

  typedef struct packed {
    logic  accept;
    mode_t mode;
    logic  s_zero;
    logic  cnt_zero;
    logic  flag;
    logic  out_busy;
  } cond_t;

  // Program labels
  localparam pc_t AD_IDLE  = 5'd0;
  localparam pc_t AD_DISP  = 5'd1;
  localparam pc_t AD_PRED0 = 5'd2;
  localparam pc_t AD_PRED1 = 5'd3;
  localparam pc_t AD_PRED2 = 5'd4;
  localparam pc_t AD_UPD0  = 5'd5;
  localparam pc_t AD_UPD1  = 5'd6;
  localparam pc_t AD_UPD2  = 5'd7;
  localparam pc_t AD_UPD3  = 5'd8;
  localparam pc_t AD_UPD4  = 5'd9;
  localparam pc_t AD_UPD5  = 5'd10;
  localparam pc_t AD_ENT0  = 5'd11;
  localparam pc_t AD_ENT1  = 5'd12;
  localparam pc_t AD_LEV0  = 5'd13;
  localparam pc_t AD_LEV1  = 5'd14;
  localparam pc_t AD_RST0  = 5'd15;
  localparam pc_t AD_EMIT  = 5'd16;

  function automatic ctl_t ucode_rom(input pc_t pc);
    ctl_t w;
    w = '{mul: MUL_NONE, alu: ALU_NOP, jc: JC_NEXT, target: AD_IDLE};
    unique case (pc)
      AD_IDLE:  begin w.alu = ALU_LOAD; w.jc = JC_WAIT; end
      AD_DISP:  begin w.jc = JC_MODE; end
      AD_PRED0: begin w.mul = MUL_DT; end
      AD_PRED1: begin w.alu = ALU_ROUND; end
      AD_PRED2: begin w.alu = ALU_PRED; w.jc = JC_GOTO; w.target = AD_EMIT; end
      AD_UPD0:  begin w.alu = ALU_SUM; end
      AD_UPD1:  begin w.jc = JC_SZERO; w.target = AD_EMIT; end
      AD_UPD2:  begin w.alu = ALU_DIV; w.jc = JC_LOOP; w.target = AD_UPD2; end
      AD_UPD3:  begin w.mul = MUL_GAIN; end
      AD_UPD4:  begin w.mul = MUL_COV; w.alu = ALU_ROUND; end
      AD_UPD5:  begin w.alu = ALU_UPD; w.jc = JC_GOTO; w.target = AD_EMIT; end
      AD_ENT0:  begin w.jc = JC_FLAG_SET; w.target = AD_EMIT; end
      AD_ENT1:  begin w.alu = ALU_ENTER; w.jc = JC_GOTO; w.target = AD_EMIT; end
      AD_LEV0:  begin w.jc = JC_FLAG_CLR; w.target = AD_EMIT; end
      AD_LEV1:  begin w.alu = ALU_LEAVE; w.jc = JC_GOTO; w.target = AD_EMIT; end
      AD_RST0:  begin w.alu = ALU_RESTORE; w.jc = JC_GOTO; w.target = AD_EMIT; end
      AD_EMIT:  begin w.alu = ALU_EMIT; w.jc = JC_EMIT; w.target = AD_IDLE; end
      default:  begin w.jc = JC_GOTO; w.target = AD_IDLE; end
    endcase
    return w;
  endfunction

endpackage

// File: design/dskv_seq.sv
// Microcode sequencer: step counter, control store and jump logic.
module dskv_seq
  import dskv_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  cond_t cond,
  output ctl_t  ctl
);

  pc_t pc_r, pc_nxt, pc_inc;

  assign ctl    = ucode_rom(pc_r);
  assign pc_inc = pc_r + pc_t'(1);

  function automatic pc_t mode_entry(input mode_t m);
    pc_t a;
    a = AD_EMIT;
    unique case (m)
      MODE_PREDICT: a = AD_PRED0;
      MODE_WHEEL,
      MODE_IMU:     a = AD_UPD0;
      MODE_ENTER:   a = AD_ENT0;
      MODE_LEAVE:   a = AD_LEV0;
      MODE_RESET:   a = AD_RST0;
      default:      a = AD_EMIT;  // unused modes just report
    endcase
    return a;
  endfunction

  always_comb begin
    unique case (ctl.jc)
      JC_NEXT:     pc_nxt = pc_inc;
      JC_GOTO:     pc_nxt = ctl.target;
      JC_WAIT:     pc_nxt = cond.accept ? pc_inc : pc_r;
      JC_MODE:     pc_nxt = mode_entry(cond.mode);
      JC_SZERO:    pc_nxt = cond.s_zero ? ctl.target : pc_inc;
      JC_LOOP:     pc_nxt = cond.cnt_zero ? pc_inc : ctl.target;
      JC_FLAG_SET: pc_nxt = cond.flag ? ctl.target : pc_inc;
      JC_FLAG_CLR: pc_nxt = cond.flag ? pc_inc : ctl.target;
      JC_EMIT:     pc_nxt = cond.out_busy ? pc_r : ctl.target;
      default:     pc_nxt = AD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= AD_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// File: design/dual_scalar_kalman_velocity_core.sv
// Top level: two scalar Kalman velocity filters on a microcoded datapath.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+---------------------------------------------
//  in_     | in        | in_valid / in_stall  | mode, channel, sample
//  out_    | out       | out_valid / out_stall| angular_estimate, linear_estimate, high_unc.
//  cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data (cfg_ready always high)
//
// One word at a time. An update runs the bit-serial gain divider that resolves
// one quotient bit per cycle; values are Q16.16 at the default FRAC_BITS.
// Reset (synchronous, rst_n low) restores the filters and the register defaults.
// The result sits in an output register, so a stalled output holds only the
// final step of the next word; in_stall is low only at the idle step.
module dual_scalar_kalman_velocity_core
  import dskv_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // input words
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_mode,
  input  logic               in_channel,
  input  logic signed [31:0] in_sample,
  // result words
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_angular_estimate,
  output logic signed [31:0] out_linear_estimate,
  output logic               out_high_uncertainty,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  // Widths. Multiplier operands are 33-bit signed, enough for unsigned 32-bit
  // covariances and the 33-bit innovation.
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int KW     = FRAC_BITS + 1;          // gain, 0 .. 1.0
  localparam int CNT_W  = $clog2(FRAC_BITS + 1);
  localparam int STEP_W = PROD_W - FRAC_BITS + 1;
  localparam int SUM_W  = STEP_W + 1;

  localparam logic [31:0] ONE_FX  = 32'(64'd1 << FRAC_BITS);
  localparam logic [31:0] DT_RST  = (ONE_FX + 32'd50) / 32'd100;
  localparam logic [31:0] Q_RST   = (ONE_FX + 32'd5) / 32'd10;
  localparam logic [31:0] RW_RST  = ONE_FX >> 1;
  localparam logic [31:0] RI_RST  = ONE_FX;
  localparam logic [KW-1:0] ONE_K = KW'(ONE_FX);
  localparam logic [PROD_W-1:0] HALF_FX = {{(PROD_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;

  ctl_t  ctl;
  cond_t cond;

  // configuration registers
  logic [31:0] dt_r, qa_r, ql_r, rwa_r, ria_r, rwl_r, ril_r;

  // filter state, index 0 angular, 1 linear
  logic signed [31:0] val_r   [2];
  logic        [31:0] cov_r   [2];
  logic        [31:0] noise_r [2];
  logic               flag_r;

  // captured word
  mode_t              mode_r;
  logic               ch_r;
  logic signed [31:0] sample_r;

  // work registers
  logic signed [PROD_W-1:0] prod_r;
  logic signed [STEP_W-1:0] step_r, step_nxt;
  logic        [32:0]       s_r;
  logic        [33:0]       rem_r;
  logic        [KW-1:0]     k_r;
  logic        [CNT_W-1:0]  cnt_r;

  // result register
  logic               out_valid_r;
  logic signed [31:0] out_ang_r, out_lin_r;
  logic               out_flag_r;
  logic               out_busy;

  dskv_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .cond  (cond),
    .ctl   (ctl)
  );

  assign in_stall  = (ctl.alu != ALU_LOAD);
  assign cfg_ready = 1'b1;
  assign out_busy  = out_valid_r && out_stall;

  assign cond.accept   = in_valid && !in_stall;
  assign cond.mode     = mode_r;
  assign cond.s_zero   = (s_r == 33'd0);
  assign cond.cnt_zero = (cnt_r == '0);
  assign cond.flag     = flag_r;
  assign cond.out_busy = out_busy;

  assign out_valid            = out_valid_r;
  assign out_angular_estimate = out_ang_r;
  assign out_linear_estimate  = out_lin_r;
  assign out_high_uncertainty = out_flag_r;

  // selected channel
  logic signed [31:0] cur_val;
  logic        [31:0] cur_cov, cur_noise, cur_r;
  assign cur_val   = val_r[ch_r];
  assign cur_cov   = cov_r[ch_r];
  assign cur_noise = noise_r[ch_r];

  always_comb begin
    if (mode_r == MODE_WHEEL) begin
      cur_r = ch_r ? rwl_r : rwa_r;
    end else begin
      cur_r = ch_r ? ril_r : ria_r;
    end
  end

  // shared multiplier
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [32:0]       diff;
  logic        [KW-1:0]     one_minus_k;

  assign diff        = $signed({sample_r[31], sample_r}) - $signed({cur_val[31], cur_val});
  assign one_minus_k = ONE_K - k_r;
  assign mul_p       = mul_a * mul_b;

  always_comb begin
    unique case (ctl.mul)
      MUL_DT: begin
        mul_a = $signed({1'b0, dt_r});
        mul_b = $signed({sample_r[31], sample_r});
      end
      MUL_GAIN: begin
        mul_a = diff;
        mul_b = $signed({{(MUL_W-KW){1'b0}}, k_r});
      end
      MUL_COV: begin
        mul_a = $signed({1'b0, cur_cov});
        mul_b = $signed({{(MUL_W-KW){1'b0}}, one_minus_k});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // round to nearest, halves away from zero
  logic [PROD_W-1:0]           mag, mag_rnd;
  logic [PROD_W-FRAC_BITS-1:0] rnd;

  assign mag     = prod_r[PROD_W-1] ? (~prod_r + PROD_W'(1)) : prod_r;
  assign mag_rnd = mag + HALF_FX;
  assign rnd     = mag_rnd[PROD_W-1:FRAC_BITS];
  assign step_nxt = prod_r[PROD_W-1] ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});

  // estimate plus step, saturated to 32 bits
  logic signed [SUM_W-1:0] vsum;
  logic signed [31:0]      val_sat;

  assign vsum = $signed({{(SUM_W-32){cur_val[31]}}, cur_val})
              + $signed({step_r[STEP_W-1], step_r});

  always_comb begin
    if ((&vsum[SUM_W-1:31]) || !(|vsum[SUM_W-1:31])) begin
      val_sat = vsum[31:0];
    end else begin
      val_sat = vsum[SUM_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
  end

  // covariance terms
  logic [32:0]        cov_sum;
  logic [31:0]        cov_pred;
  logic [PROD_W-1:0]  cov_prod;
  logic [31:0]        cov_upd;

  assign cov_sum  = {1'b0, cur_cov} + {1'b0, cur_noise};
  assign cov_pred = cov_sum[32] ? U32_MAX : cov_sum[31:0];
  assign cov_prod = prod_r + HALF_FX;
  assign cov_upd  = cov_prod[FRAC_BITS+31:FRAC_BITS];  // never exceeds P

  // one restoring divide step for K = (P << FRAC_BITS) / (P + R)
  logic        div_ge;
  logic [33:0] div_rem;
  assign div_ge  = rem_r >= {1'b0, s_r};
  assign div_rem = div_ge ? (rem_r - {1'b0, s_r}) : rem_r;

  function automatic logic [31:0] sat_x10(input logic [31:0] x);
    logic [35:0] p;
    p = {1'b0, x, 3'b000} + {3'b000, x, 1'b0};
    return (|p[35:32]) ? 32'hFFFF_FFFF : p[31:0];
  endfunction

  function automatic logic [31:0] sat_x2(input logic [31:0] x);
    return x[31] ? 32'hFFFF_FFFF : {x[30:0], 1'b0};
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r  <= DT_RST;
      qa_r  <= Q_RST;
      ql_r  <= Q_RST;
      rwa_r <= RW_RST;
      ria_r <= RI_RST;
      rwl_r <= RW_RST;
      ril_r <= RI_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TIME_STEP: dt_r  <= cfg_data;
        REG_ANG_Q:     qa_r  <= cfg_data;
        REG_LIN_Q:     ql_r  <= cfg_data;
        REG_WHEEL_ANG: rwa_r <= cfg_data;
        REG_IMU_ANG:   ria_r <= cfg_data;
        REG_WHEEL_LIN: rwl_r <= cfg_data;
        REG_IMU_LIN:   ril_r <= cfg_data;
        default: ;  // index outside the map
      endcase
    end
  end

  // filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r[0]   <= '0;
      val_r[1]   <= '0;
      cov_r[0]   <= ONE_FX;
      cov_r[1]   <= ONE_FX;
      noise_r[0] <= Q_RST;
      noise_r[1] <= Q_RST;
      flag_r     <= 1'b0;
    end else begin
      unique case (ctl.alu)
        ALU_PRED: begin
          val_r[ch_r] <= val_sat;
          cov_r[ch_r] <= cov_pred;
        end
        ALU_UPD: begin
          val_r[ch_r] <= val_sat;
          cov_r[ch_r] <= cov_upd;
        end
        ALU_ENTER: begin
          flag_r     <= 1'b1;
          noise_r[0] <= sat_x10(qa_r);
          noise_r[1] <= sat_x10(ql_r);
          cov_r[0]   <= sat_x2(cov_r[0]);
          cov_r[1]   <= sat_x2(cov_r[1]);
        end
        ALU_LEAVE: begin
          flag_r     <= 1'b0;
          noise_r[0] <= qa_r;
          noise_r[1] <= ql_r;
        end
        ALU_RESTORE: begin
          val_r[0]   <= '0;
          val_r[1]   <= '0;
          cov_r[0]   <= ONE_FX;
          cov_r[1]   <= ONE_FX;
          noise_r[0] <= qa_r;
          noise_r[1] <= ql_r;
          flag_r     <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // captured word and work registers (payload, no reset)
  always_ff @(posedge clk) begin
    if (ctl.alu == ALU_LOAD && in_valid) begin
      mode_r   <= mode_t'(in_mode);
      ch_r     <= in_channel;
      sample_r <= in_sample;
    end
    if (ctl.mul != MUL_NONE) begin
      prod_r <= mul_p;
    end
    if (ctl.alu == ALU_ROUND) begin
      step_r <= step_nxt;
    end
    if (ctl.alu == ALU_SUM) begin
      s_r   <= {1'b0, cur_cov} + {1'b0, cur_r};
      rem_r <= {2'b00, cur_cov};
      k_r   <= '0;
      cnt_r <= CNT_W'(FRAC_BITS);
    end else if (ctl.alu == ALU_DIV) begin
      k_r   <= {k_r[KW-2:0], div_ge};
      rem_r <= {div_rem[32:0], 1'b0};
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.alu == ALU_EMIT && !out_busy) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.alu == ALU_EMIT && !out_busy) begin
      out_ang_r  <= val_r[0];
      out_lin_r  <= val_r[1];
      out_flag_r <= flag_r;
    end
  end

endmodule

// File: design/dskv_checker.sv
// Port-level checks for the dual Kalman velocity core, with its bind.
module dskv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_angular_estimate,
  input logic [31:0] out_linear_estimate,
  input logic        out_high_uncertainty,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // one word in flight: an accepted word blocks the input next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  // after reset the core is idle and holds no result
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not idle after reset");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_angular_estimate)
      && $stable(out_linear_estimate) && $stable(out_high_uncertainty))
    else $error("stalled result changed");

  // configuration writes are never refused
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind dual_scalar_kalman_velocity_core dskv_checker u_dskv_checker (.*);

// File: dv/tb_dual_scalar_kalman_velocity_core.sv
// Self-checking testbench for the dual scalar Kalman velocity core.
module tb_dual_scalar_kalman_velocity_core;
  import dskv_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam bit [63:0] ONE_Q = 64'd1 << FRAC;
  localparam bit [63:0] HALF_Q = 64'd1 << (FRAC - 1);
  localparam longint S32_MAX = 64'sh0000_0000_7fff_ffff;
  localparam longint S32_MIN = 64'shffff_ffff_8000_0000;
  localparam bit [63:0] U32_MAX = 64'h0000_0000_ffff_ffff;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_WORDS = 1050;
  localparam int PHASES = 5;
  localparam int MAX_PRINTS = 40;
  // mode codes the block leaves unused, and the one register index with no register
  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam logic [2:0] REG_SPARE = 3'd7;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic [2:0]         in_mode = '0;
  logic               in_channel = 1'b0;
  logic signed [31:0] in_sample = '0;
  logic               out_stall = 1'b0;
  logic               cfg_valid = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  wire                in_stall;
  wire                out_valid;
  wire signed [31:0]  out_angular_estimate;
  wire signed [31:0]  out_linear_estimate;
  wire                out_high_uncertainty;
  wire                cfg_ready;

  always #4 clk = ~clk;

  dual_scalar_kalman_velocity_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_mode              (in_mode),
    .in_channel           (in_channel),
    .in_sample            (in_sample),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_angular_estimate (out_angular_estimate),
    .out_linear_estimate  (out_linear_estimate),
    .out_high_uncertainty (out_high_uncertainty),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  // One result word: both estimates plus the high-uncertainty flag.
  typedef struct packed {
    logic signed [31:0] ang;
    logic signed [31:0] lin;
    logic               unc;
  } velocity_word_t;

  // Filter state as the block should hold it, plus a shadow of the registers.
  logic signed [31:0] ang_est, lin_est;
  logic [31:0]        ang_cov, lin_cov;
  logic [31:0]        ang_q_now, lin_q_now;
  logic               uncertain;
  logic [31:0]        reg_shadow [0:7];

  velocity_word_t expected_words[$];

  int  mismatches = 0;
  int  words_sent = 0;
  int  words_checked = 0;
  int  cfg_writes = 0;
  int  cycles = 0;
  bit  idling = 1'b1;

  // ---------------------------------------------------------------------------
  // Fixed-point helpers
  // ---------------------------------------------------------------------------
  function automatic logic signed [31:0] sat_signed(longint x);
    if (x > S32_MAX) return S32_MAX[31:0];
    if (x < S32_MIN) return S32_MIN[31:0];
    return x[31:0];
  endfunction

  function automatic logic [31:0] sat_unsigned(bit [63:0] x);
    return (x > U32_MAX) ? 32'hffff_ffff : x[31:0];
  endfunction

  // Drop the fraction bits, rounding to nearest with halves away from zero.
  function automatic longint round_q(longint x);
    bit [63:0] mag;
    mag = (x < 0) ? -x : x;
    mag = (mag + HALF_Q) >> FRAC;
    return (x < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  // ---------------------------------------------------------------------------
  // Filter predictor
  // ---------------------------------------------------------------------------
  task automatic reset_filters();
    ang_est = '0;
    lin_est = '0;
    ang_cov = ONE_Q[31:0];
    lin_cov = ONE_Q[31:0];
    ang_q_now = reg_shadow[REG_ANG_Q];
    lin_q_now = reg_shadow[REG_LIN_Q];
    uncertain = 1'b0;
  endtask

  task automatic kf_predict(inout logic signed [31:0] est, inout logic [31:0] cov,
                            input logic [31:0] q, input logic signed [31:0] accel);
    longint prod;
    prod = longint'(reg_shadow[REG_TIME_STEP]) * longint'(accel);
    est = sat_signed(longint'(est) + round_q(prod));
    cov = sat_unsigned({32'b0, cov} + {32'b0, q});
  endtask

  task automatic kf_update(inout logic signed [31:0] est, inout logic [31:0] cov,
                           input logic [31:0] r, input logic signed [31:0] meas);
    bit [63:0] denom;
    bit [63:0] gain;
    longint    innov;
    denom = {32'b0, cov} + {32'b0, r};
    // zero innovation variance: gain is zero, nothing moves
    if (denom != 0) begin
      gain = ({32'b0, cov} << FRAC) / denom;
      innov = longint'(meas) - longint'(est);
      est = sat_signed(longint'(est) + round_q(longint'(gain) * innov));
      cov = sat_unsigned(((ONE_Q - gain) * {32'b0, cov} + HALF_Q) >> FRAC);
    end
  endtask

  // Apply one accepted input word and queue the result word it must produce.
  task automatic step_filters(logic [2:0] m, logic ch, logic signed [31:0] smp);
    case (m)
      MODE_PREDICT: begin
        if (ch) kf_predict(lin_est, lin_cov, lin_q_now, smp);
        else kf_predict(ang_est, ang_cov, ang_q_now, smp);
      end
      MODE_WHEEL: begin
        if (ch) kf_update(lin_est, lin_cov, reg_shadow[REG_WHEEL_LIN], smp);
        else kf_update(ang_est, ang_cov, reg_shadow[REG_WHEEL_ANG], smp);
      end
      MODE_IMU: begin
        if (ch) kf_update(lin_est, lin_cov, reg_shadow[REG_IMU_LIN], smp);
        else kf_update(ang_est, ang_cov, reg_shadow[REG_IMU_ANG], smp);
      end
      MODE_ENTER: begin
        if (!uncertain) begin
          uncertain = 1'b1;
          ang_q_now = sat_unsigned({32'b0, reg_shadow[REG_ANG_Q]} * 64'd10);
          lin_q_now = sat_unsigned({32'b0, reg_shadow[REG_LIN_Q]} * 64'd10);
          ang_cov = sat_unsigned({32'b0, ang_cov} * 64'd2);
          lin_cov = sat_unsigned({32'b0, lin_cov} * 64'd2);
        end
      end
      MODE_LEAVE: begin
        if (uncertain) begin
          uncertain = 1'b0;
          ang_q_now = reg_shadow[REG_ANG_Q];
          lin_q_now = reg_shadow[REG_LIN_Q];
        end
      end
      MODE_RESET: reset_filters();
      default: ;
    endcase
    expected_words.push_back('{ang: ang_est, lin: lin_est, unc: uncertain});
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Offer one input word, with random idle cycles ahead of it while idling is set, and hold it
  // until the block takes it. valid stays high into the next word when no
  // idle cycle falls between them.
  task automatic send_word(logic [2:0] m, logic ch, logic [31:0] smp);
    while (idling && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= m;
    in_channel <= ch;
    in_sample <= smp;
    do @(posedge clk); while (in_stall);
    step_filters(m, ch, smp);
    words_sent++;
  endtask

  // Stop offering and wait until every expected word has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    reg_shadow[idx] = d;
    cfg_writes++;
  endtask

  // Full register set, written back to back while the block is idle. The
  // unmapped index gets a random value each time; it must change nothing.
  task automatic program_regs(logic [31:0] dt, logic [31:0] aq, logic [31:0] lq,
                              logic [31:0] wa, logic [31:0] ia, logic [31:0] wl,
                              logic [31:0] il);
    drain();
    write_reg(REG_TIME_STEP, dt);
    write_reg(REG_ANG_Q, aq);
    write_reg(REG_LIN_Q, lq);
    write_reg(REG_WHEEL_ANG, wa);
    write_reg(REG_IMU_ANG, ia);
    write_reg(REG_WHEEL_LIN, wl);
    write_reg(REG_IMU_LIN, il);
    write_reg(REG_SPARE, $urandom);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result checking and receiver stalls
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("mismatch at cycle %0d, word %0d: %s got %h want %h",
               cycles, words_checked, what, got, want);
  endtask

  always @(posedge clk) begin
    velocity_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      words_checked++;
      if (expected_words.size() == 0) begin
        report_mismatch("word with nothing pending", out_angular_estimate, 32'd0);
      end else begin
        want = expected_words.pop_front();
        if (out_angular_estimate !== want.ang)
          report_mismatch("angular_estimate", out_angular_estimate, want.ang);
        if (out_linear_estimate !== want.lin)
          report_mismatch("linear_estimate", out_linear_estimate, want.lin);
        if (out_high_uncertainty !== want.unc)
          report_mismatch("high_uncertainty", {31'b0, out_high_uncertainty}, {31'b0, want.unc});
      end
    end
    out_stall <= idling && ($urandom_range(99) < 38);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still pending", cycles,
               expected_words.size());
      $display("tb_dual_scalar_kalman_velocity_core: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic logic [2:0] pick_mode();
    int roll;
    roll = $urandom_range(99);
    if (roll < 34) return MODE_PREDICT;
    if (roll < 54) return MODE_WHEEL;
    if (roll < 74) return MODE_IMU;
    if (roll < 83) return MODE_ENTER;
    if (roll < 92) return MODE_LEAVE;
    if (roll < 96) return MODE_RESET;
    return (roll < 98) ? MODE_SPARE_LO : MODE_SPARE_HI;
  endfunction

  // Mostly realistic velocities and accelerations (within +-16.0), with
  // full-range values and the two extremes mixed in.
  function automatic logic [31:0] pick_sample();
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2, 3, 4: return $urandom;
      default: return 32'($urandom_range(1 << 21)) - 32'(1 << 20);
    endcase
  endfunction

  // Reset-default registers: every mode on both channels, repeated mode
  // changes, the unused mode codes and the reset mode.
  task automatic test_mode_sequence();
    send_word(MODE_PREDICT, 1'b0, 32'h7fff_ffff);
    send_word(MODE_PREDICT, 1'b1, 32'h8000_0000);
    send_word(MODE_WHEEL, 1'b0, 32'h0002_0000);
    send_word(MODE_IMU, 1'b0, 32'hfffe_0000);
    send_word(MODE_WHEEL, 1'b1, 32'h0001_8000);
    send_word(MODE_IMU, 1'b1, 32'h0000_0001);
    send_word(MODE_ENTER, 1'b0, 32'h0000_0000);
    send_word(MODE_ENTER, 1'b1, 32'hffff_ffff);   // already high: no change
    send_word(MODE_PREDICT, 1'b0, 32'h0001_0000);
    send_word(MODE_LEAVE, 1'b1, 32'h5555_5555);
    send_word(MODE_LEAVE, 1'b0, 32'haaaa_aaaa);   // already normal: no change
    send_word(MODE_SPARE_LO, 1'b1, 32'h1234_5678);
    send_word(MODE_SPARE_HI, 1'b0, 32'hedcb_a987);
    send_word(MODE_RESET, 1'b1, 32'h7fff_ffff);
    drain();
  endtask

  // All registers at full scale: estimates and covariances pin at their limits.
  task automatic test_saturation();
    program_regs('1, '1, '1, '1, '1, '1, '1);
    send_word(MODE_PREDICT, 1'b0, 32'h7fff_ffff);
    send_word(MODE_PREDICT, 1'b1, 32'h8000_0000);
    send_word(MODE_ENTER, 1'b0, 32'h0);
    send_word(MODE_WHEEL, 1'b0, 32'h8000_0000);
    drain();
  endtask

  // R = 0: the first update drives P to zero, the second sees P + R = 0.
  task automatic test_zero_innovation();
    program_regs('0, '0, '0, '0, '0, '0, '0);
    send_word(MODE_WHEEL, 1'b0, 32'h0003_0000);
    send_word(MODE_WHEEL, 1'b0, 32'hfff0_0000);
    send_word(MODE_IMU, 1'b1, 32'h8000_0000);
    send_word(MODE_IMU, 1'b1, 32'h7fff_ffff);
    drain();
  endtask

  // New process noise defaults only take hold at the next mode change.
  task automatic test_deferred_noise();
    program_regs(32'd655, 32'h0001_0000, 32'h0003_0000, 32'h0000_8000,
                 32'h0001_0000, 32'h0000_8000, 32'h0001_0000);
    send_word(MODE_PREDICT, 1'b1, 32'h0000_4000);
    send_word(MODE_LEAVE, 1'b0, 32'h0);
    send_word(MODE_PREDICT, 1'b1, 32'hffff_c000);
    drain();
  endtask

  // Random traffic over several register settings. One phase runs with no
  // idling on either side; in each phase the sender holds off halfway until
  // every pending word has come back.
  task automatic test_random_traffic();
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: program_regs(32'd655, 32'd6554, 32'd6554, 32'd32768, 32'd65536,
                        32'd32768, 32'd65536);
        1: program_regs($urandom_range(1 << 17), $urandom_range(1 << 20),
                        $urandom_range(1 << 20), $urandom_range(1 << 18),
                        $urandom_range(1 << 18), $urandom_range(1 << 18),
                        $urandom_range(1 << 18));
        2: program_regs($urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom);
        3: program_regs('1, '1, '1, '1, '1, '1, '1);
        default: program_regs($urandom_range(1 << 12), '0, '0, '0, '0, '0, '0);
      endcase
      idling = (p != 2);
      for (int i = 0; i < RANDOM_WORDS / PHASES; i++) begin
        if (i == RANDOM_WORDS / PHASES / 2) drain();
        send_word(pick_mode(), 1'($urandom_range(1)), pick_sample());
      end
    end
    drain();
    idling = 1'b1;
  endtask

  initial begin
    reg_shadow[REG_TIME_STEP] = 32'((ONE_Q + 64'd50) / 64'd100);
    reg_shadow[REG_ANG_Q] = 32'((ONE_Q + 64'd5) / 64'd10);
    reg_shadow[REG_LIN_Q] = 32'((ONE_Q + 64'd5) / 64'd10);
    reg_shadow[REG_WHEEL_ANG] = 32'(ONE_Q >> 1);
    reg_shadow[REG_IMU_ANG] = 32'(ONE_Q);
    reg_shadow[REG_WHEEL_LIN] = 32'(ONE_Q >> 1);
    reg_shadow[REG_IMU_LIN] = 32'(ONE_Q);
    reg_shadow[REG_SPARE] = '0;
    reset_filters();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_mode_sequence();
    test_saturation();
    test_zero_innovation();
    test_deferred_noise();
    test_random_traffic();

    // nothing pending; give a stray late word time to show up
    drain();
    repeat (64) @(posedge clk);

    $display("sent %0d words over all modes and spare codes, %0d register writes",
             words_sent, cfg_writes);
    $display("checked %0d result words incl. saturation and zero-variance updates",
             words_checked);
    if (mismatches == 0) begin
      $display("tb_dual_scalar_kalman_velocity_core: clean");
    end else begin
      $display("tb_dual_scalar_kalman_velocity_core: errors");
    end
    $finish;
  end

endmodule
